[hw/rtl/mlps_pkg.sv]
// Shared types and constants for the multiplexed LED PWM scanner.
package mlps_pkg;

	// Request codes carried in req_type.
	localparam logic [1:0] REQ_TICK   = 2'd0;
	localparam logic [1:0] REQ_SINGLE = 2'd1;
	localparam logic [1:0] REQ_RGB    = 2'd2;

	// Channel number width: an rgb write reaches at most channel 31*3+2.
	localparam int CH_W = 7;
	localparam int MAP_N = 1 << CH_W;

	// Number of channel writes one request can cause.
	localparam int SLOTS = 3;

	// Request beat.
	typedef struct packed {
		logic [1:0] req_type;
		logic [4:0] target_index;
		logic [7:0] level_value;
		logic [7:0] red_level;
		logic [7:0] green_level;
		logic [7:0] blue_level;
	} req_t;

	// Result beat.
	typedef struct packed {
		logic [1:0] active_row;
		logic [5:0] pin_pattern;
	} res_t;

	// One channel write issued by the write sequencer.
	typedef struct packed {
		logic            en;
		logic [CH_W-1:0] ch;
		logic [7:0]      level;
	} wr_slot_t;

endpackage

[hw/rtl/multiplexed_led_pwm_scanner.sv]
// Top level of the multiplexed LED PWM scanner.
//
// Request channel (req_valid, req_stall, req): each beat is a tick, a single
// channel write or an rgb write of one LED; code 3 is taken and ignored.
// Result channel (res_valid, res_stall, res): one beat per tick with the
// active ground row and the pin pattern; writes give no result.
// The channel levels live in one small RAM per pin lane, addressed by row,
// so a tick reads its whole row in one access.
// Throughput: one request per cycle while req_stall is low. With fewer than
// three pins per row an rgb write stalls requests while its channels are
// written one at a time, since they share a lane write port. A tick's result
// comes from the RAM read, then the compare into the output register.
// Reset clears the per-channel valid bits, so all levels read as zero, and
// sets row and brightness counters to their last values. No clearing pass.
// While the receiver stalls, the result holds and one more tick can wait in
// the read stage; a further request is then stalled, as during rgb sequencing.
module multiplexed_led_pwm_scanner
	import mlps_pkg::*;
#(
	parameter int ROWS         = 4,
	parameter int PINS_PER_ROW = 6,
	parameter int LEVELS       = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int LANE_W = (PINS_PER_ROW > 1) ? $clog2(PINS_PER_ROW) : 1;
	localparam int LVL_W  = $clog2(LEVELS);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
	localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(LEVELS - 1);

	typedef logic [ROW_W-1:0]  row_tab_t  [MAP_N];
	typedef logic [LANE_W-1:0] lane_tab_t [MAP_N];

	// Channel number to row and lane, worked out at elaboration.
	function automatic row_tab_t mk_row_tab();
		row_tab_t t;
		for (int c = 0; c < MAP_N; c++) begin
			t[c] = ROW_W'(c / PINS_PER_ROW);
		end
		return t;
	endfunction

	function automatic lane_tab_t mk_lane_tab();
		lane_tab_t t;
		for (int c = 0; c < MAP_N; c++) begin
			t[c] = LANE_W'(c % PINS_PER_ROW);
		end
		return t;
	endfunction

	localparam row_tab_t  ROW_TAB  = mk_row_tab();
	localparam lane_tab_t LANE_TAB = mk_lane_tab();

	logic                 accept;
	logic                 tick_go;
	logic                 wr_go;
	logic                 busy;
	wr_slot_t [SLOTS-1:0] slot;
	logic [ROW_W-1:0]     row_q;
	logic [ROW_W-1:0]     row_nxt;
	logic [LVL_W-1:0]     bright_q;
	logic [LVL_W-1:0]     bright_nxt;
	logic                 lane_we    [PINS_PER_ROW];
	logic [ROW_W-1:0]     lane_waddr [PINS_PER_ROW];
	logic [7:0]           lane_wdata [PINS_PER_ROW];
	logic [7:0]           lane_rdata [PINS_PER_ROW];
	logic [ROWS-1:0]      vld_q      [PINS_PER_ROW];
	logic                 tick_s1;
	logic [ROW_W-1:0]     row_s1;
	logic [LVL_W-1:0]     bright_s1;
	logic [PINS_PER_ROW-1:0] vld_s1;
	logic                 s1_adv;
	logic [ROW_W+1:0]     row_ext;
	logic [5:0]           pattern;
	logic                 res_valid_q;
	res_t                 res_q;

	// Stall only during rgb sequencing or when both stages are full and stalled.
	assign req_stall = busy || (tick_s1 && res_valid_q && res_stall);
	assign accept    = req_valid && !req_stall;
	assign tick_go   = accept && (req.req_type == REQ_TICK);
	assign wr_go     = accept && (req.req_type == REQ_SINGLE || req.req_type == REQ_RGB);

	mlps_wrseq #(
		.ROWS         (ROWS),
		.PINS_PER_ROW (PINS_PER_ROW)
	) u_wrseq (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (wr_go),
		.req    (req),
		.slot   (slot),
		.busy   (busy)
	);

	// Next row and brightness for a tick.
	always_comb begin
		row_nxt    = (row_q == ROW_LAST) ? '0 : row_q + ROW_W'(1);
		bright_nxt = bright_q;
		if (row_q == ROW_LAST) begin
			bright_nxt = (bright_q == LVL_LAST) ? '0 : bright_q + LVL_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= ROW_LAST;
			bright_q <= LVL_LAST;
		end else if (tick_go) begin
			row_q    <= row_nxt;
			bright_q <= bright_nxt;
		end
	end

	// Steer the channel writes onto the lane write ports.
	always_comb begin
		for (int l = 0; l < PINS_PER_ROW; l++) begin
			lane_we[l]    = 1'b0;
			lane_waddr[l] = '0;
			lane_wdata[l] = '0;
			for (int j = 0; j < SLOTS; j++) begin
				if (slot[j].en && LANE_TAB[slot[j].ch] == LANE_W'(l)) begin
					lane_we[l]    = 1'b1;
					lane_waddr[l] = ROW_TAB[slot[j].ch];
					lane_wdata[l] = slot[j].level;
				end
			end
		end
	end

	// One RAM and one row of valid bits per lane.
	for (genvar l = 0; l < PINS_PER_ROW; l++) begin : g_lane
		mlps_ram #(
			.WIDTH (8),
			.DEPTH (ROWS)
		) u_ram (
			.clk   (clk),
			.we    (lane_we[l]),
			.waddr (lane_waddr[l]),
			.wdata (lane_wdata[l]),
			.re    (tick_go),
			.raddr (row_nxt),
			.rdata (lane_rdata[l])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[l] <= '0;
			end else if (lane_we[l]) begin
				vld_q[l][lane_waddr[l]] <= 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (tick_go) begin
				vld_s1[l] <= vld_q[l][row_nxt];
			end
		end
	end

	// Read stage: holds the tick while the RAM data comes out.
	assign s1_adv = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_s1 <= 1'b0;
		end else if (tick_go) begin
			tick_s1 <= 1'b1;
		end else if (s1_adv) begin
			tick_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_go) begin
			row_s1    <= row_nxt;
			bright_s1 <= bright_nxt;
		end
	end

	// Compare each lane level against the brightness counter.
	for (genvar k = 0; k < 6; k++) begin : g_pin
		if (k < PINS_PER_ROW) begin : g_on
			assign pattern[k] = vld_s1[k] && (lane_rdata[k] > 8'(bright_s1));
		end else begin : g_off
			assign pattern[k] = 1'b0;
		end
	end

	assign row_ext = {2'b00, row_s1};

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_adv) begin
			res_valid_q <= tick_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && tick_s1) begin
			res_q.active_row  <= row_ext[1:0];
			res_q.pin_pattern <= pattern;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// A tick always lands in the read stage.
	a_tick_enters: assert property (@(posedge clk) disable iff (!arst_n)
		tick_go |=> tick_s1)
		else $error("accepted tick did not reach the read stage");

	// Brightness moves exactly when the row wraps.
	a_bright_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_go && row_q == ROW_LAST) |=> (bright_q != $past(bright_q)))
		else $error("brightness did not advance on row wrap");

	a_bright_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_go && row_q != ROW_LAST) |=> $stable(bright_q))
		else $error("brightness changed without row wrap");

	// No tick or write is taken while an rgb write is still being sequenced.
	a_no_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !tick_go && !wr_go)
		else $error("request accepted during write sequencing");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= ROW_LAST)
		else $error("row counter out of range");

endmodule

[hw/rtl/mlps_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module mlps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read data is registered and holds while re is low; a read of the entry
	// written at the same edge returns its old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/mlps_wrseq.sv]
// Write decoder and sequencer: turns write requests into channel writes.
module mlps_wrseq
	import mlps_pkg::*;
#(
	parameter int ROWS         = 4,
	parameter int PINS_PER_ROW = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  req_t                 req,
	output wr_slot_t [SLOTS-1:0] slot,
	output logic                 busy
);

	localparam int CHANNELS = ROWS * PINS_PER_ROW;
	// With fewer than three pins per row the three rgb channels may share a lane.
	localparam bit SPLIT = (PINS_PER_ROW < 3);
	localparam logic [SLOTS-1:0] FIRST_SLOTS = SPLIT ? 3'b001 : 3'b111;
	localparam logic [SLOTS-1:0] LATER_SLOTS = SPLIT ? 3'b110 : 3'b000;
	localparam logic [8:0] CH_LIM = 9'(CHANNELS);

	logic [CH_W-1:0]  idx;
	logic [CH_W-1:0]  base;
	logic             single_ok;
	logic             rgb_ok;
	logic [SLOTS-1:0] pend_q;
	logic [SLOTS-1:0] pick;
	logic [CH_W-1:0]  base_q;
	logic [7:0]       red_q;
	logic [7:0]       green_q;
	logic [CH_W-1:0]  src_base;
	logic [7:0]       src_red;
	logic [7:0]       src_green;

	// Channel base of an rgb write is the LED number times three.
	assign idx  = {2'b00, req.target_index};
	assign base = {1'b0, req.target_index, 1'b0} + idx;

	assign single_ok = go && (req.req_type == REQ_SINGLE) && ({2'b00, idx} < CH_LIM);
	assign rgb_ok    = go && (req.req_type == REQ_RGB) && (({2'b00, base} + 9'd2) < CH_LIM);

	// Lowest pending channel goes out first.
	assign pick = pend_q & (~pend_q + 3'd1);
	assign busy = (pend_q != '0);

	assign src_base  = busy ? base_q  : base;
	assign src_red   = busy ? red_q   : req.red_level;
	assign src_green = busy ? green_q : req.green_level;

	// Slot 0 is the blue channel or the single channel, 1 green, 2 red.
	always_comb begin
		slot[0].ch    = (!busy && req.req_type == REQ_SINGLE) ? idx : src_base;
		slot[0].level = (!busy && req.req_type == REQ_SINGLE) ? req.level_value
			: req.blue_level;
		slot[1].ch    = src_base + 7'd1;
		slot[1].level = src_green;
		slot[2].ch    = src_base + 7'd2;
		slot[2].level = src_red;
		slot[0].en    = 1'b0;
		slot[1].en    = 1'b0;
		slot[2].en    = 1'b0;
		if (busy) begin
			slot[0].en = pick[0];
			slot[1].en = pick[1];
			slot[2].en = pick[2];
		end else if (single_ok) begin
			slot[0].en = 1'b1;
		end else if (rgb_ok) begin
			slot[0].en = FIRST_SLOTS[0];
			slot[1].en = FIRST_SLOTS[1];
			slot[2].en = FIRST_SLOTS[2];
		end
	end

	// Pending rgb channels that could not be written when the request was taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (busy) begin
			pend_q <= pend_q & ~pick;
		end else if (rgb_ok) begin
			pend_q <= LATER_SLOTS;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy && rgb_ok) begin
			base_q  <= base;
			red_q   <= req.red_level;
			green_q <= req.green_level;
		end
	end

endmodule

[verif/multiplexed_led_pwm_scanner_checker.sv]
// Checker for the LED PWM scanner: mirrors the level store and scan counters, compares results.
`timescale 1ns / 100ps

module multiplexed_led_pwm_scanner_checker
	import mlps_pkg::*;
#(
	parameter int ROWS         = 4,
	parameter int PINS_PER_ROW = 6,
	parameter int LEVELS       = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req,
	input  logic res_valid,
	input  logic res_stall,
	input  res_t res,
	output int   fail_count,
	output int   outstanding,
	output int   checked_count,
	output int   write_count
);

	localparam int CHANNELS  = ROWS * PINS_PER_ROW;
	localparam int PATTERN_W = 6;

	// Mirror of the block's state.
	logic [7:0] level_store [CHANNELS];
	int         scan_row;
	int         scan_level;

	// Scan results still to come, oldest first.
	res_t expected_scans [$];

	int fails;
	int checks;
	int writes;

	// Compare one result beat against the oldest predicted scan.
	task automatic check_scan(input res_t got);
		res_t want;
		if (expected_scans.size() == 0) begin
			$error("result beat with no scan pending: active_row %0d pin_pattern %b",
				got.active_row, got.pin_pattern);
			fails++;
		end else begin
			want = expected_scans.pop_front();
			checks++;
			if (got.active_row !== want.active_row) begin
				$error("active_row: expected %0d, actual %0d", want.active_row, got.active_row);
				fails++;
			end
			if (got.pin_pattern !== want.pin_pattern) begin
				$error("pin_pattern: expected %b, actual %b", want.pin_pattern, got.pin_pattern);
				fails++;
			end
		end
	endtask

	// Update the mirrored state for one request beat and predict its scan, if any.
	task automatic apply_request(input req_t r);
		int   base;
		int   ch;
		res_t scan;
		case (r.req_type)
			REQ_SINGLE: begin
				writes++;
				if (int'(r.target_index) < CHANNELS)
					level_store[r.target_index] = r.level_value;
			end
			REQ_RGB: begin
				writes++;
				base = int'(r.target_index) * 3;
				// The whole LED is dropped when its red channel falls off the end.
				if (base + 2 < CHANNELS) begin
					level_store[base + 2] = r.red_level;
					level_store[base + 1] = r.green_level;
					level_store[base]     = r.blue_level;
				end
			end
			REQ_TICK: begin
				scan_row++;
				if (scan_row >= ROWS) begin
					scan_row   = 0;
					scan_level = (scan_level + 1) % LEVELS;
				end
				scan.active_row  = scan_row[1:0];
				scan.pin_pattern = '0;
				// Pins beyond the pattern width are simply lost.
				for (int k = 0; k < PINS_PER_ROW && k < PATTERN_W; k++) begin
					ch = scan_row * PINS_PER_ROW + k;
					if (ch < CHANNELS && int'(level_store[ch]) > scan_level)
						scan.pin_pattern[k] = 1'b1;
				end
				expected_scans.push_back(scan);
			end
			default: begin
				// Unknown request code: accepted and ignored.
			end
		endcase
	endtask

	// Results are checked before the same edge's request is predicted, since a
	// tick never answers at the edge where it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (level_store[i])
				level_store[i] = 8'd0;
			scan_row   = ROWS - 1;
			scan_level = LEVELS - 1;
			expected_scans.delete();
			fails  = 0;
			checks = 0;
			writes = 0;
			fail_count    <= 0;
			outstanding   <= 0;
			checked_count <= 0;
			write_count   <= 0;
		end else begin
			if (res_valid && !res_stall)
				check_scan(res);
			if (req_valid && !req_stall)
				apply_request(req);
			fail_count    <= fails;
			outstanding   <= expected_scans.size();
			checked_count <= checks;
			write_count   <= writes;
		end
	end

endmodule

[verif/multiplexed_led_pwm_scanner_tb.sv]
// Testbench top for the LED PWM scanner: clock, reset, request stimulus, result stalls, verdict.
`timescale 1ns / 100ps

module multiplexed_led_pwm_scanner_tb;
	import mlps_pkg::*;

	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam int         PHASES      = 4;
	localparam int         PHASE_BEATS = 475;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic res_valid;
	logic res_stall;
	res_t res;

	int fail_count;
	int outstanding;
	int checked_count;
	int write_count;

	// Gap-free modes for the sender and the receiver.
	bit tx_calm;
	bit rx_calm;

	multiplexed_led_pwm_scanner uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	multiplexed_led_pwm_scanner_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req           (req),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.res           (res),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.checked_count (checked_count),
		.write_count   (write_count)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Run time limit.
	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Mostly no gap, sometimes a few cycles, rarely a long one.
	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic req_t make_req(logic [1:0] kind, int idx, int lvl, int r, int g, int b);
		req_t q;
		q.req_type     = kind;
		q.target_index = idx[4:0];
		q.level_value  = lvl[7:0];
		q.red_level    = r[7:0];
		q.green_level  = g[7:0];
		q.blue_level   = b[7:0];
		return q;
	endfunction

	// Level near the brightness range most of the time, so thresholds get crossed.
	function automatic int rand_level();
		if ($urandom_range(0, 2) == 0)
			return $urandom_range(0, 255);
		return $urandom_range(0, 70);
	endfunction

	// Random request: ticks dominate, writes mostly land in range, a few unknown codes.
	function automatic req_t rand_item();
		req_t q;
		int   r;
		q = make_req(REQ_TICK, $urandom_range(0, 31), $urandom_range(0, 255),
			$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
		r = $urandom_range(0, 99);
		if (r < 20) begin
			q.req_type     = REQ_SINGLE;
			q.level_value  = 8'(rand_level());
			q.target_index = 5'(($urandom_range(0, 9) == 0) ? $urandom_range(24, 31)
				: $urandom_range(0, 23));
		end else if (r < 40) begin
			q.req_type     = REQ_RGB;
			q.red_level    = 8'(rand_level());
			q.green_level  = 8'(rand_level());
			q.blue_level   = 8'(rand_level());
			q.target_index = 5'(($urandom_range(0, 9) == 0) ? $urandom_range(8, 31)
				: $urandom_range(0, 7));
		end else if (r < 44) begin
			q.req_type = REQ_UNKNOWN;
		end
		return q;
	endfunction

	// Present one beat and hold it until it is taken.
	task automatic drive_beat(input req_t b);
		req       <= b;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// Drop valid for a number of cycles, with junk on the idle payload.
	task automatic idle_req(input int n);
		if (n > 0) begin
			req_valid <= 1'b0;
			req       <= rand_item();
			repeat (n) @(posedge clk);
		end
	endtask

	// Hold off the sender until every pending scan has come back.
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Receiver stalls.
	initial begin
		int n;
		res_stall = 1'b0;
		@(posedge clk);
		forever begin
			n = rx_calm ? 0 : gap_cycles();
			if (n == 0) begin
				res_stall <= 1'b0;
				@(posedge clk);
			end else begin
				res_stall <= 1'b1;
				repeat (n) @(posedge clk);
				res_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		req_t directed [$];
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		tx_calm   = 1'b1;
		rx_calm   = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats: reset scan, field extremes, ignored writes, threshold edges.
		directed.push_back(make_req(REQ_TICK,    0,   0,   0,   0,   0));
		directed.push_back(make_req(REQ_SINGLE,  0, 255,   0,   0,   0));
		directed.push_back(make_req(REQ_SINGLE, 23,   1,   0,   0,   0));
		directed.push_back(make_req(REQ_SINGLE,  5, 128,   0,   0,   0));
		directed.push_back(make_req(REQ_SINGLE, 24, 255, 255, 255, 255));
		directed.push_back(make_req(REQ_SINGLE, 31, 255, 255, 255, 255));
		directed.push_back(make_req(REQ_RGB,     0,   0, 255,   0, 170));
		directed.push_back(make_req(REQ_RGB,     7, 255,   1, 255, 127));
		directed.push_back(make_req(REQ_RGB,     8, 255, 255, 255, 255));
		directed.push_back(make_req(REQ_RGB,    31, 255, 255, 255, 255));
		directed.push_back(make_req(REQ_UNKNOWN, 31, 255, 255, 255, 255));
		repeat (4) directed.push_back(make_req(REQ_TICK, 31, 255, 255, 255, 255));
		directed.push_back(make_req(REQ_SINGLE,  6,   2,   0,   0,   0));
		directed.push_back(make_req(REQ_SINGLE,  7,   1,   0,   0,   0));
		directed.push_back(make_req(REQ_SINGLE, 12,   0,   0,   0,   0));
		repeat (5) directed.push_back(make_req(REQ_TICK, 0, 0, 0, 0, 0));
		foreach (directed[i])
			drive_beat(directed[i]);
		drain();

		// Random phases: no gaps, gaps on both sides, sender gaps only, receiver stalls only.
		for (int p = 0; p < PHASES; p++) begin
			tx_calm = (p == 0) || (p == 3);
			rx_calm = (p == 0) || (p == 2);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				drive_beat(rand_item());
				if (!tx_calm)
					idle_req(gap_cycles());
				if ($urandom_range(0, 199) == 0)
					drain();
			end
			drain();
		end

		// Let any stray result surface before the verdict.
		repeat (10) @(posedge clk);
		$display("Checked %0d scan results and applied %0d level writes, including",
			checked_count, write_count);
		$display("out-of-range writes, unknown codes, and runs with and without stalls.");
		if (fail_count == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
